// ===== rtl/lpcc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpcc_pkg: shared constants and types for the luma preserving color clamp
// Channel widths, luma weights and divider sizing used by every stage.
// ----------------------------------------------------------------------------
package lpcc_pkg;

  // One color channel as it travels through the pipeline.
  localparam int CH_W = 12;
  typedef logic signed [CH_W-1:0] chan_t;

  // Luma weights; they add up to ten thousand.
  localparam logic [12:0] W_RED   = 13'd2126;
  localparam logic [12:0] W_GREEN = 13'd7152;
  localparam logic [12:0] W_BLUE  = 13'd722;

  // Same weights as signed operands for the luma products.
  localparam logic signed [13:0] WS_RED   = 14'sd2126;
  localparam logic signed [13:0] WS_GREEN = 14'sd7152;
  localparam logic signed [13:0] WS_BLUE  = 14'sd722;

  localparam logic signed [12:0] WHITE_LEVEL = 13'sd255;
  localparam logic signed [27:0] LUMA_WHITE  = 28'sd2550000;

  // Weighted sums of demand or capacity fit in 25 bits.
  localparam int ACC_W = 25;
  // Magnitude of a demand or capacity fits in 12 bits.
  localparam int MAG_W = 12;
  // Dividend: magnitude times the moved amount.
  localparam int NUM_W = ACC_W + MAG_W;
  // Quotient magnitude never exceeds the channel's own demand or capacity.
  localparam int Q_W = 12;
  localparam int DIV_STAGES = Q_W;

endpackage

// ===== rtl/lpcc_spread.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpcc_spread: one spreading pass of the clamp
// Moves weighted demand into channels with capacity, in four setup stages,
// a twelve stage restoring divider and one final add stage.
// ----------------------------------------------------------------------------
module lpcc_spread (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 second,
  input  logic                 in_valid,
  input  lpcc_pkg::chan_t      in_ch [3],
  output logic                 out_valid,
  output lpcc_pkg::chan_t      out_ch [3]
);

  localparam int AW = lpcc_pkg::ACC_W;
  localparam int MW = lpcc_pkg::MAG_W;
  localparam int NW = lpcc_pkg::NUM_W;
  localparam int QW = lpcc_pkg::Q_W;
  localparam int DS = lpcc_pkg::DIV_STAGES;

  logic [12:0] wgt [3];
  assign wgt[0] = lpcc_pkg::W_RED;
  assign wgt[1] = lpcc_pkg::W_GREEN;
  assign wgt[2] = lpcc_pkg::W_BLUE;

  // Stage 1: demand, capacity and weighted parts per channel.
  logic signed [12:0] need [3];
  logic signed [12:0] room [3];
  logic                s1_valid;
  lpcc_pkg::chan_t     s1_ch [3];
  logic [AW-1:0]       s1_wn [3];
  logic [AW-1:0]       s1_wr [3];
  logic [MW-1:0]       s1_mag [3];
  logic                s1_rpos [3];
  logic                s1_neg [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      need[i] = second ? -{in_ch[i][11], in_ch[i]}
                       : {in_ch[i][11], in_ch[i]} - lpcc_pkg::WHITE_LEVEL;
      room[i] = -need[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= in_valid;
    end
    for (int i = 0; i < 3; i++) begin
      s1_ch[i]   <= in_ch[i];
      s1_wn[i]   <= (need[i] > 0) ? AW'(wgt[i]) * AW'(need[i][MW-1:0]) : '0;
      s1_wr[i]   <= (room[i] > 0) ? AW'(wgt[i]) * AW'(room[i][MW-1:0]) : '0;
      s1_mag[i]  <= room[i][12] ? MW'(-room[i]) : room[i][MW-1:0];
      s1_rpos[i] <= (room[i] > 0);
      s1_neg[i]  <= second ? (room[i] > 0) : room[i][12];
    end
  end

  // Stage 2: total demand and total capacity.
  logic                s2_valid;
  lpcc_pkg::chan_t     s2_ch [3];
  logic [AW-1:0]       s2_work;
  logic [AW-1:0]       s2_cap;
  logic [MW-1:0]       s2_mag [3];
  logic                s2_rpos [3];
  logic                s2_neg [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= s1_valid;
    end
    s2_work <= s1_wn[0] + s1_wn[1] + s1_wn[2];
    s2_cap  <= s1_wr[0] + s1_wr[1] + s1_wr[2];
    s2_ch   <= s1_ch;
    s2_mag  <= s1_mag;
    s2_rpos <= s1_rpos;
    s2_neg  <= s1_neg;
  end

  // Stage 3: amount moved, divisor per channel and the no-op case.
  logic                s3_valid;
  lpcc_pkg::chan_t     s3_ch [3];
  logic [AW-1:0]       s3_act;
  logic [AW-1:0]       s3_den [3];
  logic                s3_skip;
  logic [MW-1:0]       s3_mag [3];
  logic                s3_neg [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else begin
      s3_valid <= s2_valid;
    end
    s3_act  <= (s2_work < s2_cap) ? s2_work : s2_cap;
    s3_skip <= (s2_work == '0) || (s2_cap == '0);
    for (int i = 0; i < 3; i++) begin
      s3_den[i] <= s2_rpos[i] ? s2_cap : s2_work;
    end
    s3_ch  <= s2_ch;
    s3_mag <= s2_mag;
    s3_neg <= s2_neg;
  end

  // Stage 4 and divider: index 0 holds the dividend, each later index one
  // more quotient bit, most significant first.
  logic                dv_valid [DS+1];
  lpcc_pkg::chan_t     dv_ch    [DS+1][3];
  logic [NW-1:0]       dv_rem   [DS+1][3];
  logic [QW-1:0]       dv_q     [DS+1][3];
  logic [AW-1:0]       dv_den   [DS+1][3];
  logic                dv_neg   [DS+1][3];
  logic                dv_skip  [DS+1];

  logic [NW-1:0]       trial    [DS][3];

  always_comb begin
    for (int j = 0; j < DS; j++) begin
      for (int i = 0; i < 3; i++) begin
        trial[j][i] = NW'(dv_den[j][i]) << (DS - 1 - j);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int j = 0; j <= DS; j++) begin
        dv_valid[j] <= 1'b0;
      end
    end else begin
      dv_valid[0] <= s3_valid;
      for (int j = 0; j < DS; j++) begin
        dv_valid[j+1] <= dv_valid[j];
      end
    end
    // Dividend load.
    dv_ch[0]   <= s3_ch;
    dv_skip[0] <= s3_skip;
    for (int i = 0; i < 3; i++) begin
      dv_rem[0][i] <= NW'(s3_mag[i]) * NW'(s3_act);
      dv_q[0][i]   <= '0;
      dv_den[0][i] <= s3_den[i];
      dv_neg[0][i] <= s3_neg[i];
    end
    // One compare and subtract per stage.
    for (int j = 0; j < DS; j++) begin
      dv_ch[j+1]   <= dv_ch[j];
      dv_skip[j+1] <= dv_skip[j];
      for (int i = 0; i < 3; i++) begin
        dv_den[j+1][i] <= dv_den[j][i];
        dv_neg[j+1][i] <= dv_neg[j][i];
        if (dv_rem[j][i] >= trial[j][i]) begin
          dv_rem[j+1][i] <= dv_rem[j][i] - trial[j][i];
          dv_q[j+1][i]   <= dv_q[j][i] | (QW'(1) << (DS - 1 - j));
        end else begin
          dv_rem[j+1][i] <= dv_rem[j][i];
          dv_q[j+1][i]   <= dv_q[j][i];
        end
      end
    end
  end

  // Final stage: apply the signed share, truncated toward zero.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= dv_valid[DS];
    end
    for (int i = 0; i < 3; i++) begin
      if (dv_skip[DS]) begin
        out_ch[i] <= dv_ch[DS][i];
      end else if (dv_neg[DS][i]) begin
        out_ch[i] <= dv_ch[DS][i] - $signed(dv_q[DS][i]);
      end else begin
        out_ch[i] <= dv_ch[DS][i] + $signed(dv_q[DS][i]);
      end
    end
  end

endmodule

// ===== rtl/luma_preserving_color_clamp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// luma_preserving_color_clamp: desaturating clamp of one signed RGB word
// Pipeline: two luma stages, two spreading passes of 17 stages each
// and one packing register.
// Throughput: one word per clock; busy is always low and the pipeline
// never stalls, since the receiver cannot hold results off.
// Reset: rst clears every valid bit; data registers are not reset.
// ----------------------------------------------------------------------------
module luma_preserving_color_clamp (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic signed [11:0] red_in,
  input  logic signed [11:0] green_in,
  input  logic signed [11:0] blue_in,
  output logic               done,
  output logic [31:0]        packed_pixel
);

  assign busy = 1'b0;

  // Stage 1: weighted channel products.
  logic                     t1_valid;
  lpcc_pkg::chan_t          t1_ch [3];
  logic signed [25:0]       t1_p  [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      t1_valid <= 1'b0;
    end else begin
      t1_valid <= start && !busy;
    end
    t1_ch[0] <= red_in;
    t1_ch[1] <= green_in;
    t1_ch[2] <= blue_in;
    t1_p[0]  <= 26'(red_in)   * 26'(lpcc_pkg::WS_RED);
    t1_p[1]  <= 26'(green_in) * 26'(lpcc_pkg::WS_GREEN);
    t1_p[2]  <= 26'(blue_in)  * 26'(lpcc_pkg::WS_BLUE);
  end

  // Stage 2: luma and the white and black shortcuts.
  logic signed [27:0]       luma;
  logic                     t2_valid;
  lpcc_pkg::chan_t          t2_ch [3];

  assign luma = 28'(t1_p[0]) + 28'(t1_p[1]) + 28'(t1_p[2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      t2_valid <= 1'b0;
    end else begin
      t2_valid <= t1_valid;
    end
    for (int i = 0; i < 3; i++) begin
      if (luma > lpcc_pkg::LUMA_WHITE) begin
        t2_ch[i] <= 12'sd255;
      end else if (luma <= 0) begin
        t2_ch[i] <= '0;
      end else begin
        t2_ch[i] <= t1_ch[i];
      end
    end
  end

  // Two spreading passes: excess above white, then negative debt.
  logic                     p1_valid;
  lpcc_pkg::chan_t          p1_ch [3];
  logic                     p2_valid;
  lpcc_pkg::chan_t          p2_ch [3];

  lpcc_spread u_pass_hi (
    .clk       (clk),
    .rst       (rst),
    .second    (1'b0),
    .in_valid  (t2_valid),
    .in_ch     (t2_ch),
    .out_valid (p1_valid),
    .out_ch    (p1_ch)
  );

  lpcc_spread u_pass_lo (
    .clk       (clk),
    .rst       (rst),
    .second    (1'b1),
    .in_valid  (p1_valid),
    .in_ch     (p1_ch),
    .out_valid (p2_valid),
    .out_ch    (p2_ch)
  );

  // Packing: channels sign extended and wrapped into 32 bits.
  logic [31:0] pack_word;
  assign pack_word = ({{20{p2_ch[0][11]}}, p2_ch[0]} << 16)
                   + ({{20{p2_ch[1][11]}}, p2_ch[1]} << 8)
                   +  {{20{p2_ch[2][11]}}, p2_ch[2]};

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= p2_valid;
    end
    packed_pixel <= pack_word;
  end

`ifndef SYNTHESIS
  a_word_out: assert property (@(posedge clk) disable iff (rst)
    start |-> ##37 done) else $error("accepted word gave no result");
  a_no_extra: assert property (@(posedge clk) disable iff (rst)
    !start |-> ##37 !done) else $error("result without an accepted word");
  a_black: assert property (@(posedge clk) disable iff (rst)
    (start && red_in == 12'sd0 && green_in == 12'sd0 && blue_in == 12'sd0)
    |-> ##37 (packed_pixel == 32'd0)) else $error("black input not black");
`endif

endmodule
